FILE: hdl/e2r_pkg.sv
`timescale 1ns / 1ps

package e2r_pkg;

   // field widths and fixed-point formats
   localparam int ANGLE_W         = 26;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int OUT_W           = 32;
   localparam int OUT_FRAC_BITS   = 30;
   localparam int THR_W           = 10;
   localparam int IFB             = 61;
   localparam int Q_W             = 64;
   localparam int MAG_W           = 62;
   localparam int HALF_MW         = MAG_W / 2;

   // cordic depth
   localparam int TRIG_STAGES = 24;
   localparam int STAGE_IDX_W = $clog2(TRIG_STAGES);

   // pipeline latencies
   localparam int QMUL_LAT = 4;
   localparam int TRIG_LAT = 4 + TRIG_STAGES + 1;
   localparam int PIPE_LAT = TRIG_LAT + 2 * QMUL_LAT + 1;

   // packed stream widths
   localparam int REQ_DATA_W = ((3 * ANGLE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((9 * OUT_W + 7) / 8) * 8;
   localparam int ENTRIES    = 9;

   // angle constants, degrees with ANGLE_FRAC_BITS fraction bits
   localparam int ANGLE_EXT_W = ANGLE_W + 1;
   localparam logic signed [ANGLE_EXT_W-1:0] FULL_TURN = ANGLE_EXT_W'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [ANGLE_EXT_W-1:0] HALF_TURN = ANGLE_EXT_W'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [ANGLE_EXT_W-1:0] QUARTER_TURN = ANGLE_EXT_W'(90 << ANGLE_FRAC_BITS);
   localparam int RED_W = $clog2((90 << ANGLE_FRAC_BITS) + 1);

   // degree to radian scale, split for two narrow multipliers
   localparam logic [Q_W-1:0] PI_Q61    = 64'h6487ED5110B4611A;
   localparam logic [Q_W-1:0] DEG2RAD   = PI_Q61 / 180;
   localparam int             DEG_W     = $clog2(DEG2RAD + 1);
   localparam int             K_SPLIT   = DEG_W / 2;
   localparam int             K_HI_W    = DEG_W - K_SPLIT;
   localparam logic [K_SPLIT-1:0] K_LO  = DEG2RAD[K_SPLIT-1:0];
   localparam logic [K_HI_W-1:0]  K_HI  = DEG2RAD[DEG_W-1:K_SPLIT];

   // q2.61 constants, and one in the q1.30 output format
   localparam logic signed [Q_W-1:0] GAIN_INV_Q61 = 64'sd1400229935014726477;
   localparam logic signed [Q_W-1:0] ONE_Q61      = 64'sd1 <<< IFB;
   localparam logic signed [Q_W-1:0] ROUND_HALF   = 64'sd1 <<< (IFB - OUT_FRAC_BITS - 1);
   localparam logic signed [OUT_W-1:0] ONE_OUT    = 32'sd1 <<< OUT_FRAC_BITS;

   typedef logic signed [Q_W-1:0] q61_type;

   typedef struct packed {
      logic negc;
      logic negs;
   } fold_type;

   // atan(2^-i) in q61, pi/4 for i = 0, else from the truncated power series, terms by long division
   function automatic logic [Q_W-1:0] atan_pow2(input int unsigned i);
      logic signed [Q_W-1:0] acc;
      logic [Q_W-1:0]        term;
      logic [Q_W-1:0]        num;
      logic [Q_W-1:0]        den;
      logic [Q_W:0]          rem;
      int unsigned           k;
      acc = '0;
      if (i == 0) begin
         acc = Q_W'(PI_Q61 >> 2);
      end else begin
         for (k = 0; (2 * k + 1) * i <= IFB; k++) begin
            num  = 64'd1 << (IFB - (2 * k + 1) * i);
            den  = Q_W'(2 * k + 1);
            rem  = '0;
            term = '0;
            for (int b = Q_W - 1; b >= 0; b--) begin
               rem = {rem[Q_W-1:0], num[b]};
               if (rem >= {1'b0, den}) begin
                  rem     = rem - {1'b0, den};
                  term[b] = 1'b1;
               end
            end
            acc = k[0] ? acc - term : acc + term;
         end
      end
      return acc;
   endfunction

endpackage

FILE: hdl/euler_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps

// channel  dir  fields (low bit up)
// req      in   tdata: yaw_deg[25:0], pitch_deg[51:26], roll_deg[77:52], zero pad
// rsp      out  tdata: row1_col1 .. row3_col3, 32 bits each, row-major
// csr      in   wr_data: flush_threshold[9:0]
//
// one beat per cycle in and out while rsp_tready stays high; a beat passes
// 4 reduction stages, 24 cordic cells, a cos/sin sign stage, two multiplier
// levels, a sum stage and the output register.
// reset clears the valid pipeline and output/skid valids, threshold to 2.
// the datapath freezes only while the skid register is full, so req_tready
// never depends on rsp_tready in the same cycle.
module euler_to_rotation_matrix_unit import e2r_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // yaw_deg, pitch_deg, roll_deg
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // row1_col1 .. row3_col3
   input  logic                  csr_wr_en,
   input  logic [THR_W-1:0]      csr_wr_data  // flush_threshold
);

   localparam int P_C1C2 = 0;
   localparam int P_C1S2 = 1;
   localparam int P_S1S2 = 2;
   localparam int P_S1C3 = 3;
   localparam int P_S1S3 = 4;
   localparam int P_C1C3 = 5;
   localparam int P_C1S3 = 6;
   localparam int P_S1C2 = 7;
   localparam int P_C2S3 = 8;
   localparam int P_C2C3 = 9;
   localparam int L1_N   = 10;
   localparam int L2_N   = 4;

   logic [THR_W-1:0]      thr_ff;
   logic                  en;
   logic [PIPE_LAT-1:0]   vld_ff, zero_ff;
   logic                  in_zero;
   q61_type               c1, s1, c2, s2, c3, s3;
   q61_type               l1_a [L1_N];
   q61_type               l1_b [L1_N];
   q61_type               l1_p [L1_N];
   q61_type               l1_d_ff [QMUL_LAT][L1_N];
   q61_type               l2_a [L2_N];
   q61_type               l2_b [L2_N];
   q61_type               l2_p [L2_N];
   q61_type               c3_d_ff [QMUL_LAT];
   q61_type               s3_d_ff [QMUL_LAT];
   q61_type               s2_d_ff [2*QMUL_LAT];
   q61_type               sum_ff [ENTRIES];
   logic [RSP_DATA_W-1:0] pipe_data;
   logic [RSP_DATA_W-1:0] rsp_data_ff, skid_data_ff;
   logic                  rsp_vld_ff, skid_vld_ff;

   // round, saturate and flush one entry
   function automatic logic [OUT_W-1:0] finish_entry(input q61_type v,
                                                     input logic [THR_W-1:0] thr);
      q61_type                 c;
      q61_type                 r;
      logic signed [OUT_W-1:0] o;
      logic [OUT_W-1:0]        mag;
      if (v > ONE_Q61) begin
         c = ONE_Q61;
      end else if (v < -ONE_Q61) begin
         c = -ONE_Q61;
      end else begin
         c = v;
      end
      r   = (c + ROUND_HALF) >>> (IFB - OUT_FRAC_BITS);
      o   = r[OUT_W-1:0];
      mag = o[OUT_W-1] ? -o : o;
      return (mag < OUT_W'(thr)) ? '0 : o;
   endfunction

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_zero = (req_tdata[ANGLE_W-1:0] == '0)
                 && (req_tdata[2*ANGLE_W-1:ANGLE_W] == '0)
                 && (req_tdata[3*ANGLE_W-1:2*ANGLE_W] == '0);

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(2);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // valid and identity flag track the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= {zero_ff[PIPE_LAT-2:0], in_zero};
      end
   end

   // cosine and sine of each angle
   e2r_trig u_trig_yaw (
      .clock     (clock),
      .en        (en),
      .angle_deg (req_tdata[ANGLE_W-1:0]),
      .cos_val   (c1),
      .sin_val   (s1)
   );

   e2r_trig u_trig_pitch (
      .clock     (clock),
      .en        (en),
      .angle_deg (req_tdata[2*ANGLE_W-1:ANGLE_W]),
      .cos_val   (c2),
      .sin_val   (s2)
   );

   e2r_trig u_trig_roll (
      .clock     (clock),
      .en        (en),
      .angle_deg (req_tdata[3*ANGLE_W-1:2*ANGLE_W]),
      .cos_val   (c3),
      .sin_val   (s3)
   );

   // first multiplier level
   assign l1_a[P_C1C2] = c1;  assign l1_b[P_C1C2] = c2;
   assign l1_a[P_C1S2] = c1;  assign l1_b[P_C1S2] = s2;
   assign l1_a[P_S1S2] = s1;  assign l1_b[P_S1S2] = s2;
   assign l1_a[P_S1C3] = s1;  assign l1_b[P_S1C3] = c3;
   assign l1_a[P_S1S3] = s1;  assign l1_b[P_S1S3] = s3;
   assign l1_a[P_C1C3] = c1;  assign l1_b[P_C1C3] = c3;
   assign l1_a[P_C1S3] = c1;  assign l1_b[P_C1S3] = s3;
   assign l1_a[P_S1C2] = s1;  assign l1_b[P_S1C2] = c2;
   assign l1_a[P_C2S3] = c2;  assign l1_b[P_C2S3] = s3;
   assign l1_a[P_C2C3] = c2;  assign l1_b[P_C2C3] = c3;

   for (genvar g = 0; g < L1_N; g++) begin : g_l1
      e2r_qmul u_qmul (
         .clock (clock),
         .en    (en),
         .a_val (l1_a[g]),
         .b_val (l1_b[g]),
         .p_val (l1_p[g])
      );
   end

   // second multiplier level, triple products
   assign l2_a[0] = l1_p[P_C1S2];  assign l2_b[0] = s3_d_ff[QMUL_LAT-1];
   assign l2_a[1] = l1_p[P_C1S2];  assign l2_b[1] = c3_d_ff[QMUL_LAT-1];
   assign l2_a[2] = l1_p[P_S1S2];  assign l2_b[2] = s3_d_ff[QMUL_LAT-1];
   assign l2_a[3] = l1_p[P_S1S2];  assign l2_b[3] = c3_d_ff[QMUL_LAT-1];

   for (genvar g = 0; g < L2_N; g++) begin : g_l2
      e2r_qmul u_qmul (
         .clock (clock),
         .en    (en),
         .a_val (l2_a[g]),
         .b_val (l2_b[g]),
         .p_val (l2_p[g])
      );
   end

   // delay lines to line up with the second level
   always_ff @(posedge clock) begin
      if (en) begin
         c3_d_ff[0] <= c3;
         s3_d_ff[0] <= s3;
         s2_d_ff[0] <= s2;
         l1_d_ff[0] <= l1_p;
         for (int i = 1; i < QMUL_LAT; i++) begin
            c3_d_ff[i] <= c3_d_ff[i-1];
            s3_d_ff[i] <= s3_d_ff[i-1];
            l1_d_ff[i] <= l1_d_ff[i-1];
         end
         for (int i = 1; i < 2 * QMUL_LAT; i++) begin
            s2_d_ff[i] <= s2_d_ff[i-1];
         end
      end
   end

   // matrix entry sums
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff[0] <= l1_d_ff[QMUL_LAT-1][P_C1C2];
         sum_ff[1] <= l2_p[0] - l1_d_ff[QMUL_LAT-1][P_S1C3];
         sum_ff[2] <= l2_p[1] + l1_d_ff[QMUL_LAT-1][P_S1S3];
         sum_ff[3] <= l1_d_ff[QMUL_LAT-1][P_S1C2];
         sum_ff[4] <= l2_p[2] + l1_d_ff[QMUL_LAT-1][P_C1C3];
         sum_ff[5] <= l2_p[3] - l1_d_ff[QMUL_LAT-1][P_C1S3];
         sum_ff[6] <= -s2_d_ff[2*QMUL_LAT-1];
         sum_ff[7] <= l1_d_ff[QMUL_LAT-1][P_C2S3];
         sum_ff[8] <= l1_d_ff[QMUL_LAT-1][P_C2C3];
      end
   end

   // final formatting, exact identity for all-zero angles
   always_comb begin
      pipe_data = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (zero_ff[PIPE_LAT-1]) begin
            pipe_data[i*OUT_W +: OUT_W] = (i % 4 == 0) ? ONE_OUT : '0;
         end else begin
            pipe_data[i*OUT_W +: OUT_W] = finish_entry(sum_ff[i], thr_ff);
         end
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            rsp_data_ff <= skid_data_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (vld_ff[PIPE_LAT-1]) begin
         if (!rsp_vld_ff || rsp_tready) begin
            rsp_data_ff <= pipe_data;
            rsp_vld_ff  <= 1'b1;
         end else begin
            skid_data_ff <= pipe_data;
            skid_vld_ff  <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

endmodule

FILE: hdl/e2r_cordic_cell.sv
`timescale 1ns / 1ps

module e2r_cordic_cell import e2r_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic [STAGE_IDX_W-1:0] shift_idx,
   input  q61_type                atan_val,
   input  q61_type                x_in,
   input  q61_type                y_in,
   input  q61_type                z_in,
   input  fold_type               flags_in,
   output q61_type                x_out,
   output q61_type                y_out,
   output q61_type                z_out,
   output fold_type               flags_out
);

   q61_type  x_ff, y_ff, z_ff;
   fold_type flags_ff;
   q61_type  dx, dy;

   // shifted cross terms, floor rounding
   assign dx = y_in >>> shift_idx;
   assign dy = x_in >>> shift_idx;

   // one rotation step toward zero residual angle
   always_ff @(posedge clock) begin
      if (en) begin
         if (!z_in[Q_W-1]) begin
            x_ff <= x_in - dx;
            y_ff <= y_in + dy;
            z_ff <= z_in - atan_val;
         end else begin
            x_ff <= x_in + dx;
            y_ff <= y_in - dy;
            z_ff <= z_in + atan_val;
         end
         flags_ff <= flags_in;
      end
   end

   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign flags_out = flags_ff;

endmodule

FILE: hdl/e2r_trig.sv
`timescale 1ns / 1ps

module e2r_trig import e2r_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [ANGLE_W-1:0] angle_deg,
   output q61_type                   cos_val,
   output q61_type                   sin_val
);

   logic signed [ANGLE_EXT_W-1:0] ext, red_in, red_ff, fold_val;
   logic [RED_W-1:0]              mag_ff;
   logic                          fold_negc;
   fold_type                      fl2_ff, fl3_ff, fl4_ff, fl_out;
   logic [RED_W+K_SPLIT-1:0]      mlo_ff;
   logic [RED_W+K_HI_W-1:0]       mhi_ff;
   logic [RED_W+DEG_W-1:0]        prod;
   q61_type                       z_ff;
   q61_type                       x_chain [TRIG_STAGES+1];
   q61_type                       y_chain [TRIG_STAGES+1];
   q61_type                       z_chain [TRIG_STAGES+1];
   fold_type                      f_chain [TRIG_STAGES+1];
   q61_type                       cos_ff, sin_ff;

   // reduce into [-180, 180)
   always_comb begin
      ext = {angle_deg[ANGLE_W-1], angle_deg};
      if (ext >= HALF_TURN) begin
         red_in = ext - FULL_TURN;
      end else if (ext < -HALF_TURN) begin
         red_in = ext + FULL_TURN;
      end else begin
         red_in = ext;
      end
   end

   // fold into [-90, 90]
   always_comb begin
      fold_negc = 1'b0;
      fold_val  = red_ff;
      if (red_ff > QUARTER_TURN) begin
         fold_val  = HALF_TURN - red_ff;
         fold_negc = 1'b1;
      end else if (red_ff < -QUARTER_TURN) begin
         fold_val  = -HALF_TURN - red_ff;
         fold_negc = 1'b1;
      end
   end

   // full product of the two partial products
   assign prod = {mhi_ff, {K_SPLIT{1'b0}}} + (RED_W + DEG_W)'(mlo_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff      <= red_in;
         fl2_ff.negc <= fold_negc;
         fl2_ff.negs <= fold_val[ANGLE_EXT_W-1];
         mag_ff      <= fold_val[ANGLE_EXT_W-1] ? RED_W'(-fold_val) : RED_W'(fold_val);
         mlo_ff      <= (RED_W + K_SPLIT)'(mag_ff) * (RED_W + K_SPLIT)'(K_LO);
         mhi_ff      <= (RED_W + K_HI_W)'(mag_ff) * (RED_W + K_HI_W)'(K_HI);
         fl3_ff      <= fl2_ff;
         z_ff        <= Q_W'(prod >> ANGLE_FRAC_BITS);
         fl4_ff      <= fl3_ff;
      end
   end

   assign x_chain[0] = GAIN_INV_Q61;
   assign y_chain[0] = '0;
   assign z_chain[0] = z_ff;
   assign f_chain[0] = fl4_ff;

   // row of rotation cells
   for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
      localparam logic [Q_W-1:0] ATAN_G = atan_pow2(g);
      e2r_cordic_cell u_cell (
         .clock     (clock),
         .en        (en),
         .shift_idx (STAGE_IDX_W'(g)),
         .atan_val  (ATAN_G),
         .x_in      (x_chain[g]),
         .y_in      (y_chain[g]),
         .z_in      (z_chain[g]),
         .flags_in  (f_chain[g]),
         .x_out     (x_chain[g+1]),
         .y_out     (y_chain[g+1]),
         .z_out     (z_chain[g+1]),
         .flags_out (f_chain[g+1])
      );
   end

   assign fl_out = f_chain[TRIG_STAGES];

   // undo the fold
   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= fl_out.negc ? -x_chain[TRIG_STAGES] : x_chain[TRIG_STAGES];
         sin_ff <= fl_out.negs ? -y_chain[TRIG_STAGES] : y_chain[TRIG_STAGES];
      end
   end

   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

FILE: hdl/e2r_qmul.sv
`timescale 1ns / 1ps

module e2r_qmul import e2r_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  q61_type a_val,
   input  q61_type b_val,
   output q61_type p_val
);

   logic               neg1_ff, neg2_ff, neg3_ff;
   logic [MAG_W-1:0]   ma_ff, mb_ff;
   logic [MAG_W-1:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [2*MAG_W-1:0] sum;
   logic [Q_W-1:0]     m_ff;
   q61_type            abs_a, abs_b, p_ff;

   assign abs_a = a_val[Q_W-1] ? -a_val : a_val;
   assign abs_b = b_val[Q_W-1] ? -b_val : b_val;

   // recombine partial products, truncate toward zero
   assign sum = {pp_hh_ff, {MAG_W{1'b0}}}
              + {{(HALF_MW){1'b0}}, pp_lh_ff, {HALF_MW{1'b0}}}
              + {{(HALF_MW){1'b0}}, pp_hl_ff, {HALF_MW{1'b0}}}
              + (2 * MAG_W)'(pp_ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= a_val[Q_W-1] ^ b_val[Q_W-1];
         ma_ff    <= abs_a[MAG_W-1:0];
         mb_ff    <= abs_b[MAG_W-1:0];
         neg2_ff  <= neg1_ff;
         pp_ll_ff <= MAG_W'(ma_ff[HALF_MW-1:0]) * MAG_W'(mb_ff[HALF_MW-1:0]);
         pp_lh_ff <= MAG_W'(ma_ff[HALF_MW-1:0]) * MAG_W'(mb_ff[MAG_W-1:HALF_MW]);
         pp_hl_ff <= MAG_W'(ma_ff[MAG_W-1:HALF_MW]) * MAG_W'(mb_ff[HALF_MW-1:0]);
         pp_hh_ff <= MAG_W'(ma_ff[MAG_W-1:HALF_MW]) * MAG_W'(mb_ff[MAG_W-1:HALF_MW]);
         neg3_ff  <= neg2_ff;
         m_ff     <= Q_W'(sum >> IFB);
         p_ff     <= neg3_ff ? -q61_type'(m_ff) : q61_type'(m_ff);
      end
   end

   assign p_val = p_ff;

endmodule

FILE: hdl/e2r_checker.sv
`timescale 1ns / 1ps

module e2r_checker import e2r_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a result beat stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

   // input is only held off while a result is waiting
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no pending rsp beat");

endmodule

bind euler_to_rotation_matrix_unit e2r_checker u_e2r_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
